>>> sv/first_fit_coalescing_allocator_assert.svh
// Assertion macros for the first-fit coalescing allocator.
// Included by the top level; no other dependencies.
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_ASSERT_SVH

// Condition on this edge implies a condition on the same edge.
`define FFCA_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("allocator check failed");

// Condition on this edge implies a condition on the next edge.
`define FFCA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("allocator check failed");

`endif

>>> sv/ffca_pkg.sv
// Shared types and constants of the first-fit coalescing allocator.
// No dependencies.
`default_nettype none
package ffca_pkg;
  localparam int HEAP_BYTES = 1048576;
  localparam int SPLIT_MARGIN = 1024;
  localparam int HEADER_BYTES = 24;
  localparam int FREE_N = 64;
  localparam int USED_N = 64;

  localparam int ADDR_W = 20;
  localparam int LEN_W = 21;
  localparam int SUM_W = 48;
  localparam int FIDX_W = $clog2(FREE_N);
  localparam int CNT_W = FIDX_W + 1;
  localparam int UIDX_W = $clog2(USED_N);

  localparam logic [LEN_W-1:0] HEAP_LEN = LEN_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } seg_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_WRITE, OP_REMOVE, OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [FIDX_W-1:0] idx;
    seg_t              data;
  } cell_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  size;
    logic [ADDR_W-1:0] blk;
  } cell_key_t;
endpackage
`default_nettype wire

>>> sv/ffca_cell.sv
// One free-segment cell of the address-ordered chain.
// Depends on ffca_pkg.
`default_nettype none
module ffca_cell import ffca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [FIDX_W-1:0] cell_idx,
  input  wire cell_cmd_t         cmd,
  input  wire cell_key_t         key,
  input  wire seg_t              left,
  input  wire seg_t              right,
  output seg_t                   data,
  output logic                   fit,
  output logic                   gt
);
  seg_t data_r, data_nxt;
  logic fit_r, gt_r;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      OP_WRITE: begin
        if (cell_idx == cmd.idx) data_nxt = cmd.data;
      end
      OP_REMOVE: begin
        if (cell_idx >= cmd.idx) data_nxt = right;
      end
      OP_INSERT: begin
        if (cell_idx > cmd.idx) data_nxt = left;
        else if (cell_idx == cmd.idx) data_nxt = cmd.data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '{start: '0, len: HEAP_LEN};
    end else begin
      data_r <= data_nxt;
    end
  end

  // Compare against the broadcast key; the result is registered.
  always_ff @(posedge clk) begin
    fit_r <= (data_r.len >= key.size);
    gt_r  <= (data_r.start > key.blk);
  end

  assign data = data_r;
  assign fit  = fit_r;
  assign gt   = gt_r;
endmodule
`default_nettype wire

>>> sv/ffca_used_mem.sv
// Allocated-block table: one write port, one registered read port.
// Depends on ffca_pkg.
`default_nettype none
module ffca_used_mem import ffca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [UIDX_W-1:0] waddr,
  input  wire seg_t              wdata,
  input  wire logic [UIDX_W-1:0] raddr,
  output seg_t                   rdata
);
  seg_t mem [USED_N];
  seg_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> sv/first_fit_coalescing_allocator.sv
// First-fit coalescing allocator: one request at a time, one result each. An allocate
// scans the free chain for the first fitting segment, then the used table for the first
// free slot, and then registers its result; a no-fit ends after all live segments and a
// full used table after the whole used table. A free of a nonzero pointer searches the
// used table for the matching entry and then scans the chain for the insertion position,
// with one more step when it merges on both sides; an unknown pointer answers after the
// whole used table, a null one goes straight to its result. Input stays stalled until the
// result is registered; a stalled result holds the block in its last state. The free table
// is a chain of 64 cells scanned one cell a cycle; the used table is a memory searched one entry a cycle.
// Depends on ffca_pkg, ffca_cell, ffca_used_mem and the assertion macro header.
`default_nettype none
`include "first_fit_coalescing_allocator_assert.svh"
module first_fit_coalescing_allocator import ffca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_command,
  input  wire logic [LEN_W-1:0]  in_request_bytes,
  input  wire logic [ADDR_W-1:0] in_release_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ADDR_W-1:0]      out_granted_address,
  output logic [1:0]             out_status,
  output logic [SUM_W-1:0]       out_requested_total
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CMP    = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_USCAN  = 9'b000001000,
    S_ALLOC  = 9'b000010000,
    S_LOOK   = 9'b000100000,
    S_FAPPLY = 9'b001000000,
    S_FREM   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic cmd_r, cmd_nxt;
  logic [LEN_W-1:0] size_r, size_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  seg_t cur_r, cur_nxt, prev_r, prev_nxt;
  logic [UIDX_W-1:0] uidx_r, uidx_nxt, uslot_r, uslot_nxt;
  logic [LEN_W-1:0] ulen_r, ulen_nxt;
  logic [USED_N-1:0] valid_r, valid_nxt;
  logic [UIDX_W-1:0] lk_r, lk_nxt, chk_idx_r, chk_idx_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [ADDR_W-1:0] res_grant_r, res_grant_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_grant_r, out_grant_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;

  cell_cmd_t cmd;
  cell_key_t key;
  seg_t cell_data [FREE_N];
  logic [FREE_N-1:0] fit_v, gt_v;

  logic mem_we;
  seg_t mem_wdata, mem_rdata;

  logic in_fire, at_end, out_free;
  seg_t rd_cell;
  logic [ADDR_W-1:0] blk;
  logic [SUM_W:0] sum_wide;
  logic [LEN_W+1:0] split_lim;
  logic split_ok, join_prev, join_next;

  assign blk = addr_r - ADDR_W'(HEADER_BYTES);
  assign key = '{size: size_r, blk: blk};

  genvar g;
  generate
    for (g = 0; g < FREE_N; g++) begin : g_cell
      seg_t lft, rgt;
      if (g == 0) begin : g_first
        assign lft = cell_data[0];
      end else begin : g_mid
        assign lft = cell_data[g-1];
      end
      if (g == FREE_N - 1) begin : g_last
        assign rgt = cell_data[FREE_N-1];
      end else begin : g_inner
        assign rgt = cell_data[g+1];
      end
      ffca_cell u_cell (
        .clk(clk), .rst_n(rst_n), .cell_idx(FIDX_W'(g)), .cmd(cmd), .key(key),
        .left(lft), .right(rgt), .data(cell_data[g]), .fit(fit_v[g]), .gt(gt_v[g])
      );
    end
  endgenerate

  ffca_used_mem u_used (
    .clk(clk), .we(mem_we), .waddr(uslot_r), .wdata(mem_wdata),
    .raddr(lk_r), .rdata(mem_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign at_end   = (idx_r == count_r);
  assign rd_cell  = cell_data[idx_r[FIDX_W-1:0]];
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(in_request_bytes);
  assign split_lim = (LEN_W+2)'(SPLIT_MARGIN + HEADER_BYTES) + (LEN_W+2)'(size_r);
  assign split_ok = ((LEN_W+2)'(cur_r.len) > split_lim) && (count_r < CNT_W'(FREE_N));
  assign join_prev = (idx_r != '0) && ((ADDR_W+2)'(prev_r.start) +
    (ADDR_W+2)'(HEADER_BYTES) + (ADDR_W+2)'(prev_r.len) == (ADDR_W+2)'(blk));
  assign join_next = !at_end && ((ADDR_W+2)'(blk) + (ADDR_W+2)'(HEADER_BYTES) +
    (ADDR_W+2)'(ulen_r) == (ADDR_W+2)'(cur_r.start));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    size_nxt = size_r;
    addr_nxt = addr_r;
    sum_nxt = sum_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    uidx_nxt = uidx_r;
    uslot_nxt = uslot_r;
    ulen_nxt = ulen_r;
    valid_nxt = valid_r;
    lk_nxt = lk_r;
    chk_idx_nxt = chk_idx_r;
    chk_v_nxt = chk_v_r;
    res_grant_nxt = res_grant_r;
    res_status_nxt = res_status_r;
    cmd = '{op: OP_NONE, idx: '0, data: '0};
    mem_we = 1'b0;
    mem_wdata = '{start: cur_r.start + ADDR_W'(HEADER_BYTES), len: size_r};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_command;
          size_nxt = in_request_bytes;
          addr_nxt = in_release_address;
          idx_nxt = '0;
          lk_nxt = '0;
          chk_v_nxt = 1'b0;
          res_grant_nxt = '0;
          res_status_nxt = ST_OK;
          if (in_command == CMD_ALLOC) begin
            sum_nxt = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            state_nxt = S_CMP;
          end else if (in_release_address == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_CMP: state_nxt = S_SCAN;
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC) begin
          if (at_end) begin
            res_status_nxt = ST_NOFIT;
            state_nxt = S_DONE;
          end else if (fit_v[idx_r[FIDX_W-1:0]]) begin
            cur_nxt = rd_cell;
            uidx_nxt = '0;
            state_nxt = S_USCAN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          cur_nxt = rd_cell;
          if (at_end || gt_v[idx_r[FIDX_W-1:0]]) begin
            state_nxt = S_FAPPLY;
          end else begin
            prev_nxt = rd_cell;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_USCAN: begin
        if (!valid_r[uidx_r]) begin
          uslot_nxt = uidx_r;
          state_nxt = S_ALLOC;
        end else if (uidx_r == UIDX_W'(USED_N - 1)) begin
          res_status_nxt = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          uidx_nxt = uidx_r + 1'b1;
        end
      end
      S_ALLOC: begin
        mem_we = 1'b1;
        valid_nxt[uslot_r] = 1'b1;
        res_grant_nxt = cur_r.start + ADDR_W'(HEADER_BYTES);
        if (split_ok) begin
          cmd = '{op: OP_WRITE, idx: idx_r[FIDX_W-1:0],
                  data: '{start: cur_r.start + ADDR_W'(HEADER_BYTES) + size_r[ADDR_W-1:0],
                          len: cur_r.len - LEN_W'(HEADER_BYTES) - size_r}};
        end else begin
          mem_wdata.len = cur_r.len;
          cmd = '{op: OP_REMOVE, idx: idx_r[FIDX_W-1:0], data: '0};
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_LOOK: begin
        // Issue one read a cycle; check the entry read on the cycle before.
        lk_nxt = lk_r + 1'b1;
        chk_idx_nxt = lk_r;
        chk_v_nxt = 1'b1;
        if (chk_v_r && valid_r[chk_idx_r] && mem_rdata.start == addr_r) begin
          valid_nxt[chk_idx_r] = 1'b0;
          ulen_nxt = mem_rdata.len;
          state_nxt = S_CMP;
        end else if (chk_v_r && chk_idx_r == UIDX_W'(USED_N - 1)) begin
          res_status_nxt = ST_UNKNOWN;
          state_nxt = S_DONE;
        end
      end
      S_FAPPLY: begin
        state_nxt = S_DONE;
        if (join_prev && join_next) begin
          cmd = '{op: OP_WRITE, idx: FIDX_W'(idx_r - 1'b1),
                  data: '{start: prev_r.start, len: prev_r.len + LEN_W'(2 * HEADER_BYTES)
                          + ulen_r + cur_r.len}};
          state_nxt = S_FREM;
        end else if (join_prev) begin
          cmd = '{op: OP_WRITE, idx: FIDX_W'(idx_r - 1'b1),
                  data: '{start: prev_r.start,
                          len: prev_r.len + LEN_W'(HEADER_BYTES) + ulen_r}};
        end else if (join_next) begin
          cmd = '{op: OP_WRITE, idx: idx_r[FIDX_W-1:0],
                  data: '{start: blk, len: cur_r.len + LEN_W'(HEADER_BYTES) + ulen_r}};
        end else if (count_r < CNT_W'(FREE_N)) begin
          cmd = '{op: OP_INSERT, idx: idx_r[FIDX_W-1:0], data: '{start: blk, len: ulen_r}};
          count_nxt = count_r + 1'b1;
        end
      end
      S_FREM: begin
        cmd = '{op: OP_REMOVE, idx: idx_r[FIDX_W-1:0], data: '0};
        count_nxt = count_r - 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_grant_nxt = out_grant_r;
    out_status_nxt = out_status_r;
    out_sum_nxt = out_sum_r;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_grant_nxt = res_grant_r;
      out_status_nxt = res_status_r;
      out_sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r <= '0;
      count_r <= CNT_W'(1);
      valid_r <= '0;
      chk_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      chk_v_r <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    size_r <= size_nxt;
    addr_r <= addr_nxt;
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    uidx_r <= uidx_nxt;
    uslot_r <= uslot_nxt;
    ulen_r <= ulen_nxt;
    lk_r <= lk_nxt;
    chk_idx_r <= chk_idx_nxt;
    res_grant_r <= res_grant_nxt;
    res_status_r <= res_status_nxt;
    out_grant_r <= out_grant_nxt;
    out_status_r <= out_status_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_granted_address = out_grant_r;
  assign out_status = out_status_r;
  assign out_requested_total = out_sum_r;

  `FFCA_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(FREE_N))
  `FFCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_fire, state_r != S_IDLE)
  `FFCA_ASSERT_NEXT(a_alloc_marks, clk, rst_n, state_r == S_ALLOC,
    valid_r[$past(uslot_r)])
  `FFCA_ASSERT_NEXT(a_merge_shrinks, clk, rst_n, state_r == S_FREM,
    count_r == $past(count_r) - 1'b1)
endmodule
`default_nettype wire

>>> verif/first_fit_coalescing_allocator_test.sv
// Self-checking testbench for the first-fit coalescing allocator.
// Predicts every result with a model of the free and used tables kept in a
// small class; depends on ffca_pkg and the allocator top level.
`default_nettype none
module first_fit_coalescing_allocator_test import ffca_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class heap_scoreboard;
    longint unsigned seg_start[$];
    longint unsigned seg_len[$];
    longint unsigned blk_addr[USED_N];
    longint unsigned blk_len[USED_N];
    bit blk_live[USED_N];
    longint unsigned req_sum;
    logic [ADDR_W-1:0] exp_grant[$];
    logic [1:0] exp_status[$];
    logic [SUM_W-1:0] exp_total[$];
    int errors;

    function new();
      seg_start = '{0};
      seg_len = '{HEAP_BYTES - HEADER_BYTES};
      req_sum = 0;
      errors = 0;
    endfunction

    function void allocate(longint unsigned size, output logic [1:0] st,
                           output longint unsigned grant);
      int i, u;
      longint unsigned base;
      grant = 0;
      req_sum = (size > 64'hFFFF_FFFF_FFFF - req_sum) ? 64'hFFFF_FFFF_FFFF
                                                      : req_sum + size;
      for (i = 0; i < seg_start.size(); i++) if (seg_len[i] >= size) break;
      if (i >= seg_start.size()) begin
        st = ST_NOFIT;
        return;
      end
      for (u = 0; u < USED_N; u++) if (!blk_live[u]) break;
      if (u >= USED_N) begin
        st = ST_FULL;
        return;
      end
      base = seg_start[i];
      if (seg_len[i] > SPLIT_MARGIN + HEADER_BYTES + size && seg_start.size() < FREE_N) begin
        seg_start[i] = base + HEADER_BYTES + size;
        seg_len[i] -= HEADER_BYTES + size;
        blk_len[u] = size;
      end else begin
        blk_len[u] = seg_len[i];
        seg_start.delete(i);
        seg_len.delete(i);
      end
      blk_addr[u] = base + HEADER_BYTES;
      blk_live[u] = 1;
      grant = base + HEADER_BYTES;
      st = ST_OK;
    endfunction

    function logic [1:0] release_block(longint unsigned addr);
      int u, p;
      longint unsigned b, len;
      bit jp, jn;
      if (addr == 0) return ST_OK;
      for (u = 0; u < USED_N; u++) if (blk_live[u] && blk_addr[u] == addr) break;
      if (u >= USED_N) return ST_UNKNOWN;
      blk_live[u] = 0;
      b = addr - HEADER_BYTES;
      len = blk_len[u];
      for (p = 0; p < seg_start.size(); p++) if (seg_start[p] > b) break;
      jp = p > 0 && seg_start[p-1] + HEADER_BYTES + seg_len[p-1] == b;
      jn = p < seg_start.size() && b + HEADER_BYTES + len == seg_start[p];
      if (jp && jn) begin
        seg_len[p-1] += 2 * HEADER_BYTES + len + seg_len[p];
        seg_start.delete(p);
        seg_len.delete(p);
      end else if (jp) seg_len[p-1] += HEADER_BYTES + len;
      else if (jn) begin
        seg_len[p] += HEADER_BYTES + len;
        seg_start[p] = b;
      end else if (seg_start.size() < FREE_N) begin
        seg_start.insert(p, b);
        seg_len.insert(p, len);
      end
      return ST_OK;
    endfunction

    function void note_request(logic cmd, logic [LEN_W-1:0] size, logic [ADDR_W-1:0] addr);
      logic [1:0] st;
      longint unsigned g;
      g = 0;
      if (cmd == CMD_ALLOC) allocate(size, st, g);
      else st = release_block(addr);
      exp_grant.push_back(g[ADDR_W-1:0]);
      exp_status.push_back(st);
      exp_total.push_back(req_sum[SUM_W-1:0]);
    endfunction

    function void check_result(logic [ADDR_W-1:0] g, logic [1:0] st, logic [SUM_W-1:0] tot);
      logic [ADDR_W-1:0] eg;
      logic [1:0] es;
      logic [SUM_W-1:0] et;
      if (exp_grant.size() == 0) begin
        $error("result with none expected");
        errors++;
        return;
      end
      eg = exp_grant.pop_front();
      es = exp_status.pop_front();
      et = exp_total.pop_front();
      if (g !== eg) begin
        $error("granted_address expected %0h actual %0h", eg, g);
        errors++;
      end
      if (st !== es) begin
        $error("status expected %0d actual %0d", es, st);
        errors++;
      end
      if (tot !== et) begin
        $error("requested_total expected %0h actual %0h", et, tot);
        errors++;
      end
    endfunction

    // pick a live pointer to free, or 0 if none
    function logic [ADDR_W-1:0] live_pointer();
      int k, n;
      n = 0;
      for (k = 0; k < USED_N; k++) if (blk_live[k]) n++;
      if (n == 0) return 0;
      n = $urandom_range(n - 1);
      for (k = 0; k < USED_N; k++)
        if (blk_live[k]) begin
          if (n == 0) return blk_addr[k][ADDR_W-1:0];
          n--;
        end
      return 0;
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_command = 0;
  logic [LEN_W-1:0] in_request_bytes = 0;
  logic [ADDR_W-1:0] in_release_address = 0;
  logic out_valid, out_stall = 0;
  logic [ADDR_W-1:0] out_granted_address;
  logic [1:0] out_status;
  logic [SUM_W-1:0] out_requested_total;
  heap_scoreboard board = new();
  bit calm = 0;
  int long_hold = 0;

  first_fit_coalescing_allocator uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall bursts, or a long hold when requested
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (long_hold > 0) begin
        out_stall <= 1;
        long_hold--;
      end else if (!calm && $urandom_range(3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1;
        repeat (n - 1) @(posedge clk);
      end else out_stall <= 0;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_granted_address, out_status, out_requested_total);

  task automatic send(logic cmd, logic [LEN_W-1:0] size, logic [ADDR_W-1:0] addr);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_request_bytes <= size;
    in_release_address <= addr;
    do @(posedge clk); while (in_stall);
    board.note_request(cmd, size, addr);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.exp_grant.size() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    logic [LEN_W-1:0] sz;
    r = $urandom_range(99);
    if (r < 50) begin
      sz = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(0, 8000));
      send(CMD_ALLOC, sz, ADDR_W'($urandom));
    end else if (r < 90) send(CMD_FREE, LEN_W'($urandom), board.live_pointer());
    else send(CMD_FREE, LEN_W'($urandom), ADDR_W'($urandom));
  endtask

  initial begin
    logic [ADDR_W-1:0] p;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero size, null free, unknown free, no fit, double free, whole heap
    send(CMD_ALLOC, '0, '0);
    send(CMD_FREE, '0, '0);
    send(CMD_FREE, '0, 20'hFFFFF);
    send(CMD_ALLOC, 21'h1FFFFF, 20'hFFFFF);
    send(CMD_ALLOC, 21'h100000, '0);
    send(CMD_ALLOC, LEN_W'(100), '0);
    p = board.live_pointer();
    send(CMD_FREE, '0, p);
    send(CMD_FREE, '0, p);
    drain();
    send(CMD_FREE, '0, board.live_pointer());
    send(CMD_FREE, '0, board.live_pointer());
    send(CMD_ALLOC, LEN_W'(HEAP_BYTES - HEADER_BYTES), '0);
    send(CMD_ALLOC, LEN_W'(1), '0);
    send(CMD_FREE, '0, board.live_pointer());
    // fill the used table and beyond, with the receiver held off
    long_hold = 300;
    repeat (70) send(CMD_ALLOC, LEN_W'($urandom_range(1, 200)), '0);
    drain();
    repeat (70) send(CMD_FREE, '0, board.live_pointer());
    drain();
    repeat (400) random_item();
    drain();
    calm = 1;
    repeat (100) random_item();
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.exp_grant.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> first_fit_coalescing_allocator.f
+incdir+sv
sv/ffca_pkg.sv
sv/ffca_cell.sv
sv/ffca_used_mem.sv
sv/first_fit_coalescing_allocator.sv
verif/first_fit_coalescing_allocator_test.sv
